/* rtl/lvd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvd_pkg
// Shared types and constants of the label volume downsampler.
// ----------------------------------------------------------------------------
package lvd_pkg;

  localparam int LabelPortW  = 64;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 11;
  localparam int RowLenW     = 9;
  localparam int RowCntW     = 9;
  localparam int SliceCntW   = 11;
  localparam int ZFactorW    = 2;
  localparam int SliceW      = 10;
  localparam int MaxSlices   = 1024;

  localparam logic [RowLenW-1:0]   RowLenRst   = 9'd256;
  localparam logic [RowCntW-1:0]   RowCntRst   = 9'd256;
  localparam logic [SliceCntW-1:0] SliceCntRst = 11'd1024;
  localparam logic [ZFactorW-1:0]  ZDeep       = 2'd2;
  localparam logic [ZFactorW-1:0]  ZFactorRst  = ZDeep;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW_LENGTH  = 2'd0,
    REG_ROW_COUNT   = 2'd1,
    REG_SLICE_COUNT = 2'd2,
    REG_Z_FACTOR    = 2'd3
  } cfg_reg_e;

  // position flags of the voxel at the head of the stream
  typedef struct packed {
    logic col_odd;
    logic row_odd;
    logic slice_odd;
    logic deep;
    logic vol_last;
  } pos_flags_t;

endpackage

/* rtl/label_volume_downsampler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_volume_downsampler
// Streams raster-ordered label voxels and votes one label per 2x2 (or 2x2x2)
// block, flagging the last block of the volume.
// ----------------------------------------------------------------------------
// Takes one voxel per clock and gives one label per completed block after
// the voxel that closes it passes the synchronous memory read stage and the
// output register. The input stalls only while a finished label
// waits in the output register and the next one is ready behind it. Even
// rows are kept as column pairs in a row memory; in 2x2x2 mode the votes of
// each even slice go to a slice memory and are read back by the odd slice
// as the preferred result. A configuration write restarts the volume.
// ----------------------------------------------------------------------------
module label_volume_downsampler #(
  parameter int MAX_ROW_LENGTH = 256,
  parameter int MAX_ROW_COUNT  = 256,
  parameter int LABEL_BITS     = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lvd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [lvd_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lvd_pkg::LabelPortW-1:0]      voxel_label_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lvd_pkg::LabelPortW-1:0]      block_label_o,
  output logic                                volume_end_o
);

  localparam int ColW    = $clog2(MAX_ROW_LENGTH);
  localparam int RowW    = $clog2(MAX_ROW_COUNT);
  localparam int HalfRow = MAX_ROW_LENGTH / 2;
  localparam int Slots   = HalfRow * (MAX_ROW_COUNT / 2);
  localparam int PairW   = (HalfRow > 1) ? $clog2(HalfRow) : 1;
  localparam int SlotW   = (Slots > 1) ? $clog2(Slots) : 1;

  typedef logic [LABEL_BITS-1:0] label_t;

  logic [ColW-1:0]     col;
  logic [RowW-1:0]     row;
  lvd_pkg::pos_flags_t flags;

  logic       in_fire, cfg_fire, blk_in, s1_free, s1_emit_go;
  label_t     cur, vote_v, final_v;
  logic [PairW-1:0] pair_addr;
  logic [SlotW-1:0] slot;

  // memories
  logic [2*LABEL_BITS-1:0] upper_mem [HalfRow];
  label_t                  first_mem [Slots];
  logic [2*LABEL_BITS-1:0] upper_rd_q;
  label_t                  first_rd_q;

  label_t left_q;

  // read stage
  logic             s1_valid_q;
  logic             s1_rec_q;
  logic             s1_fb_q;
  logic             s1_last_q;
  logic [SlotW-1:0] s1_slot_q;
  label_t           s1_c_q;
  label_t           s1_d_q;

  // output register
  logic   out_valid_q;
  label_t out_label_q;
  logic   out_last_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cur         = voxel_label_i[LABEL_BITS-1:0];

  lvd_pos_ctr #(
    .MAX_ROW_LENGTH(MAX_ROW_LENGTH),
    .MAX_ROW_COUNT (MAX_ROW_COUNT)
  ) u_pos_ctr (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_fire),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .step_i     (in_fire),
    .col_o      (col),
    .row_o      (row),
    .flags_o    (flags)
  );

  assign pair_addr = PairW'(col >> 1);
  assign slot      = SlotW'(SlotW'(row >> 1) * SlotW'(HalfRow)) + SlotW'(col >> 1);
  assign blk_in    = in_fire && flags.row_odd && flags.col_odd;

  // a recorded vote needs no output slot
  assign s1_free    = !s1_valid_q || s1_rec_q || !out_valid_q || out_ready_i;
  assign s1_emit_go = s1_valid_q && !s1_rec_q && s1_free;
  assign in_ready_o = s1_free;

  // even rows: store column pairs {left, right}
  always_ff @(posedge clk_i) begin
    if (in_fire && !flags.row_odd && flags.col_odd) begin
      upper_mem[pair_addr] <= {left_q, cur};
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_in) begin
      upper_rd_q <= upper_mem[pair_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_rec_q) begin
      first_mem[s1_slot_q] <= vote_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_in) begin
      first_rd_q <= first_mem[slot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
    end else if (in_fire) begin
      left_q <= cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= blk_in;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_in) begin
      s1_rec_q  <= flags.deep && !flags.slice_odd;
      s1_fb_q   <= flags.deep && flags.slice_odd;
      s1_last_q <= flags.vol_last;
      s1_slot_q <= slot;
      s1_c_q    <= left_q;
      s1_d_q    <= cur;
    end
  end

  function automatic label_t vote(label_t a, label_t b, label_t c, label_t d);
    label_t v;
    v = (a != '0) ? a : b;
    if (c != '0 && (v == '0 || c == a || c == b)) begin
      v = c;
    end
    if (d != '0 && (v == '0 || d == a || d == b || d == c)) begin
      v = d;
    end
    return v;
  endfunction

  assign vote_v = vote(upper_rd_q[2*LABEL_BITS-1:LABEL_BITS],
                       upper_rd_q[LABEL_BITS-1:0], s1_c_q, s1_d_q);

  // odd slice prefers the recorded vote of the slice before
  assign final_v = (s1_fb_q && first_rd_q != '0) ? first_rd_q : vote_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_emit_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_emit_go) begin
      out_label_q <= final_v;
      out_last_q  <= s1_last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign block_label_o = lvd_pkg::LabelPortW'(out_label_q);
  assign volume_end_o  = out_last_q;

`ifndef SYNTH
  a_stall_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_rec_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while a finished label is blocked");

  a_block_enters_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_in |=> s1_valid_q)
    else $error("completed block lost before the read stage");

  a_record_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_rec_q |-> !s1_last_q)
    else $error("recorded vote carries the end-of-volume flag");
`endif

endmodule

/* rtl/lvd_pos_ctr.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvd_pos_ctr
// Configuration registers and raster position counters (x, y, z) with
// end-of-volume detection.
// ----------------------------------------------------------------------------
module lvd_pos_ctr #(
  parameter int MAX_ROW_LENGTH = 256,
  parameter int MAX_ROW_COUNT  = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lvd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [lvd_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          step_i,
  output logic [$clog2(MAX_ROW_LENGTH)-1:0] col_o,
  output logic [$clog2(MAX_ROW_COUNT)-1:0]  row_o,
  output lvd_pkg::pos_flags_t           flags_o
);

  localparam int ColW = $clog2(MAX_ROW_LENGTH);
  localparam int RowW = $clog2(MAX_ROW_COUNT);
  localparam int RlW  = ($clog2(MAX_ROW_LENGTH + 1) > lvd_pkg::RowLenW) ?
                        $clog2(MAX_ROW_LENGTH + 1) : lvd_pkg::RowLenW;
  localparam int RcW  = ($clog2(MAX_ROW_COUNT + 1) > lvd_pkg::RowCntW) ?
                        $clog2(MAX_ROW_COUNT + 1) : lvd_pkg::RowCntW;
  localparam int ScW  = lvd_pkg::SliceCntW;

  logic [lvd_pkg::RowLenW-1:0]   row_length_q;
  logic [lvd_pkg::RowCntW-1:0]   row_count_q;
  logic [lvd_pkg::SliceCntW-1:0] slice_count_q;
  logic [lvd_pkg::ZFactorW-1:0]  z_factor_q;

  logic [ColW-1:0]           col_q, col_d;
  logic [RowW-1:0]           row_q, row_d;
  logic [lvd_pkg::SliceW-1:0] slice_q, slice_d;

  logic [RlW-1:0] rl_eff, rl_ext;
  logic [RcW-1:0] rc_eff, rc_ext;
  logic [ScW-1:0] sc_eff, last_z;
  logic           deep;
  logic           col_wrap, row_wrap, slice_wrap;
  logic           blk_col, blk_row, blk_slice;

  // clamp the dimensions to their legal ranges
  always_comb begin
    rl_ext = RlW'(row_length_q);
    rc_ext = RcW'(row_count_q);
    if (rl_ext == '0) begin
      rl_eff = RlW'(1);
    end else if (rl_ext > RlW'(MAX_ROW_LENGTH)) begin
      rl_eff = RlW'(MAX_ROW_LENGTH);
    end else begin
      rl_eff = rl_ext;
    end
    if (rc_ext == '0) begin
      rc_eff = RcW'(1);
    end else if (rc_ext > RcW'(MAX_ROW_COUNT)) begin
      rc_eff = RcW'(MAX_ROW_COUNT);
    end else begin
      rc_eff = rc_ext;
    end
    if (slice_count_q == '0) begin
      sc_eff = ScW'(1);
    end else if (slice_count_q > ScW'(lvd_pkg::MaxSlices)) begin
      sc_eff = ScW'(lvd_pkg::MaxSlices);
    end else begin
      sc_eff = slice_count_q;
    end
  end

  assign deep = (z_factor_q == lvd_pkg::ZDeep);

  // positions stay below the dimensions, so "next >= dim" is "pos == dim-1"
  assign col_wrap   = (RlW'(col_q) == rl_eff - RlW'(1));
  assign row_wrap   = (RcW'(row_q) == rc_eff - RcW'(1));
  assign slice_wrap = (ScW'(slice_q) == sc_eff - ScW'(1));

  // last complete block; an odd trailing column or row, and in 2x2x2 mode an odd trailing slice, is dropped
  assign last_z    = deep ? ((sc_eff & ~ScW'(1)) - ScW'(1)) : (sc_eff - ScW'(1));
  assign blk_col   = (RlW'(col_q) == (rl_eff & ~RlW'(1)) - RlW'(1));
  assign blk_row   = (RcW'(row_q) == (rc_eff & ~RcW'(1)) - RcW'(1));
  assign blk_slice = (ScW'(slice_q) == last_z);

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    slice_d = slice_q;
    if (cfg_we_i) begin
      col_d   = '0;
      row_d   = '0;
      slice_d = '0;
    end else if (step_i) begin
      if (col_wrap) begin
        col_d = '0;
        if (row_wrap) begin
          row_d   = '0;
          slice_d = slice_wrap ? '0 : slice_q + lvd_pkg::SliceW'(1);
        end else begin
          row_d = row_q + RowW'(1);
        end
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_length_q  <= lvd_pkg::RowLenRst;
      row_count_q   <= lvd_pkg::RowCntRst;
      slice_count_q <= lvd_pkg::SliceCntRst;
      z_factor_q    <= lvd_pkg::ZFactorRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lvd_pkg::REG_ROW_LENGTH:  row_length_q  <= cfg_data_i[lvd_pkg::RowLenW-1:0];
        lvd_pkg::REG_ROW_COUNT:   row_count_q   <= cfg_data_i[lvd_pkg::RowCntW-1:0];
        lvd_pkg::REG_SLICE_COUNT: slice_count_q <= cfg_data_i[lvd_pkg::SliceCntW-1:0];
        lvd_pkg::REG_Z_FACTOR:    z_factor_q    <= cfg_data_i[lvd_pkg::ZFactorW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      slice_q <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      slice_q <= slice_d;
    end
  end

  assign col_o             = col_q;
  assign row_o             = row_q;
  assign flags_o.col_odd   = col_q[0];
  assign flags_o.row_odd   = row_q[0];
  assign flags_o.slice_odd = slice_q[0];
  assign flags_o.deep      = deep;
  assign flags_o.vol_last  = blk_col && blk_row && blk_slice;

endmodule
